// ----- rtl/blup_pkg.sv -----
// Shared types, sizes and tap tables of the bilinear 2:3 RGB565 upscaler.
`default_nettype none

package blup_pkg;

    // Source frame geometry in 2x2 source blocks; the padded frame adds one column and one row.
    localparam int SRC_PAIRS_X = 80;
    localparam int SRC_PAIRS_Y = 72;
    localparam int LAST_COL    = 2 * SRC_PAIRS_X;
    localparam int LAST_ROW    = 2 * SRC_PAIRS_Y;
    localparam int LINE_DEPTH  = LAST_COL + 1;

    localparam int COL_W   = $clog2(LAST_COL + 1);
    localparam int ROW_W   = $clog2(LAST_ROW + 2);
    localparam int PIX_W   = 16;
    localparam int COORD_W = 9;
    localparam int SUM_W   = 10;
    localparam int TAP_N   = 9;
    localparam int TAP_W   = $clog2(TAP_N);

    typedef logic [PIX_W-1:0]   pixel_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [COL_W-1:0]   col_t;
    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [TAP_W-1:0]   tap_t;
    typedef logic [SUM_W-1:0]   sum_t;

    localparam tap_t LAST_TAP = TAP_W'(TAP_N - 1);

    // Screen placement offsets.
    localparam coord_t PORTRAIT_Y_OFF  = COORD_W'(26);
    localparam coord_t LANDSCAPE_X_TOP = COORD_W'(239);
    localparam coord_t LANDSCAPE_Y_OFF = COORD_W'(40);

    // Weight of each neighborhood tap (raster order over the 3x3 source window)
    // for each output position of the 3x3 result block.
    localparam logic [4:0] TAP_WEIGHT [TAP_N][TAP_N] = '{
        '{5'd16, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
        '{5'd1,  5'd3, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
        '{5'd0,  5'd3, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
        '{5'd1,  5'd0, 5'd0, 5'd3, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
        '{5'd1,  5'd3, 5'd0, 5'd3, 5'd9, 5'd0, 5'd0, 5'd0, 5'd0},
        '{5'd0,  5'd3, 5'd1, 5'd0, 5'd9, 5'd3, 5'd0, 5'd0, 5'd0},
        '{5'd0,  5'd0, 5'd0, 5'd3, 5'd0, 5'd0, 5'd1, 5'd0, 5'd0},
        '{5'd0,  5'd0, 5'd0, 5'd3, 5'd9, 5'd0, 5'd1, 5'd3, 5'd0},
        '{5'd0,  5'd0, 5'd0, 5'd0, 5'd9, 5'd3, 5'd0, 5'd3, 5'd1}
    };

    localparam logic [2:0] TAP_SHIFT [TAP_N] = '{
        3'd4, 3'd2, 3'd2, 3'd2, 3'd4, 3'd4, 3'd2, 3'd4, 3'd4
    };

    localparam logic [1:0] TAP_DX [TAP_N] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2
    };

    localparam logic [1:0] TAP_DY [TAP_N] = '{
        2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2
    };

endpackage

`default_nettype wire

// ----- rtl/blup_if.sv -----
// Handshake channel interfaces for source words, result words and configuration.
`default_nettype none

interface blup_src_if
    import blup_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   frame_start;
    pixel_t src_pixel;

    modport source (output valid, output frame_start, output src_pixel, input ready);
    modport sink   (input valid, input frame_start, input src_pixel, output ready);
endinterface

interface blup_res_if
    import blup_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t screen_x;
    coord_t screen_y;
    pixel_t out_pixel;
    logic   last_of_block;

    modport source (output valid, output screen_x, output screen_y, output out_pixel,
                    output last_of_block, input ready);
    modport sink   (input valid, input screen_x, input screen_y, input out_pixel,
                    input last_of_block, output ready);
endinterface

interface blup_cfg_if;
    logic valid;
    logic ready;
    logic landscape;

    modport source (output valid, output landscape, input ready);
    modport sink   (input valid, input landscape, output ready);
endinterface

`default_nettype wire

// ----- rtl/bilinear_upscale_2_to_3_rgb565_core.sv -----
// Top level of the streaming 1.5x bilinear RGB565 upscaler.
`default_nettype none

// The block takes RGB565 source words in raster order over a padded frame of
// (2*SRC_PAIRS_X+1) by (2*SRC_PAIRS_Y+1) pixels, whose last column and row are
// padding, and for every 2x2 source block it emits nine result words: a 3x3
// output block in raster order, each carrying its interpolated pixel and its
// screen position in portrait or rotated landscape placement. A block is
// produced when the source word at even column 2i+2 of even row 2j+2 arrives.
// Words that complete no block are taken in every cycle, also while results
// are still being sent. A word that completes a block is taken once the
// previous block's last result is being loaded, so blocks pass one at a time
// through the single result register. In an even row a block-completing word
// can therefore wait, while odd rows and the first row flow at one word per
// cycle. The word that completes a block loads the neighborhood register, and
// the block's first result is then loaded into the result register once that
// register is free. Two line memories of 2*SRC_PAIRS_X+1 words hold the last
// even and odd source rows; they are not cleared after reset and need no
// clearing pass, since every entry is written by a row before any later row
// reads it. A frame_start word restarts the counters at column 0 of row 0;
// words after the last padded pixel are consumed and ignored until the next
// frame_start. The landscape register may only be written while the block
// is idle.
module bilinear_upscale_2_to_3_rgb565_core
    import blup_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    blup_cfg_if.sink   cfg,
    blup_src_if.sink   src,
    blup_res_if.source dst
);

    // Configuration.
    logic landscape_reg;

    // Frame position of the next source word.
    col_t col_reg, col_next;
    row_t row_reg, row_next;

    // Two preceding pixels of the current row.
    pixel_t prev0_reg, prev1_reg;

    // Line memories and their registered read ports.
    pixel_t line_a [LINE_DEPTH];
    pixel_t line_b [LINE_DEPTH];
    pixel_t rd_a_reg, rd_b_reg;

    // The two older entries of each line for the 3-wide window.
    pixel_t win_a0_reg, win_a1_reg, win_b0_reg, win_b1_reg;

    // Captured neighborhood of the block being emitted.
    pixel_t nb_reg [TAP_N];
    coord_t u0_reg, v0_reg;
    logic   blk_valid_reg;
    tap_t   tap_reg;

    // Result register.
    logic   out_valid_reg;
    coord_t screen_x_reg, screen_y_reg;
    pixel_t out_pixel_reg;
    logic   last_reg;

    // Input side control.
    logic   src_acc;
    col_t   col_eff;
    row_t   row_eff;
    logic   in_frame;
    logic   emit_pos;
    logic   emit_now;
    logic   emit_step;
    logic   blk_done;
    logic   step_src;
    col_t   col_half_m1;
    row_t   row_half_m1;

    // Result datapath.
    sum_t   sum_r, sum_g, sum_b;
    sum_t   sh_r, sh_g, sh_b;
    coord_t u_cur, v_cur;
    coord_t sx, sy;

    //------------------------------------------------------------------------
    // Configuration port: always ready.
    //------------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            landscape_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            landscape_reg <= cfg.landscape;
        end
    end

    //------------------------------------------------------------------------
    // Handshake and frame position.
    //------------------------------------------------------------------------
    // A block completes at an even column of an even row, both at least two.
    assign emit_pos = (col_reg[0] == 1'b0) && (col_reg >= COL_W'(2)) &&
                      (row_reg[0] == 1'b0) && (row_reg >= ROW_W'(2)) &&
                      (row_reg <= ROW_W'(LAST_ROW));

    assign emit_step = blk_valid_reg && (!out_valid_reg || dst.ready);
    assign blk_done  = emit_step && (tap_reg == LAST_TAP);

    // Only a word at a block-completing position needs the block register.
    assign src.ready = !blk_valid_reg || blk_done || !emit_pos;
    assign src_acc   = src.valid && src.ready;

    assign col_eff  = src.frame_start ? '0 : col_reg;
    assign row_eff  = src.frame_start ? '0 : row_reg;
    assign in_frame = (row_eff <= ROW_W'(LAST_ROW));
    assign step_src = src_acc && in_frame;

    assign emit_now = step_src && (col_eff[0] == 1'b0) && (col_eff >= COL_W'(2)) &&
                      (row_eff[0] == 1'b0) && (row_eff >= ROW_W'(2));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (step_src)
        begin
            if (col_eff == COL_W'(LAST_COL))
            begin
                col_next = '0;
                row_next = row_eff + ROW_W'(1);
            end
            else
            begin
                col_next = col_eff + COL_W'(1);
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            prev0_reg <= '0;
            prev1_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (step_src)
            begin
                prev0_reg <= prev1_reg;
                prev1_reg <= src.src_pixel;
            end
        end
    end

    //------------------------------------------------------------------------
    // Line memories. The read port always fetches the entry of the column
    // that comes next, so its old contents are on hand when that word is
    // taken; the same word then overwrites the entry. Even rows go to line A,
    // odd rows to line B.
    //------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (step_src && (row_eff[0] == 1'b0))
        begin
            line_a[col_eff] <= src.src_pixel;
        end
        rd_a_reg <= line_a[col_next];
    end

    always_ff @(posedge clk)
    begin
        if (step_src && (row_eff[0] == 1'b1))
        begin
            line_b[col_eff] <= src.src_pixel;
        end
        rd_b_reg <= line_b[col_next];
    end

    always_ff @(posedge clk)
    begin
        if (step_src)
        begin
            win_a0_reg <= win_a1_reg;
            win_a1_reg <= rd_a_reg;
            win_b0_reg <= win_b1_reg;
            win_b1_reg <= rd_b_reg;
        end
    end

    //------------------------------------------------------------------------
    // Block capture: the 3x3 neighborhood and the block's output origin.
    //------------------------------------------------------------------------
    assign col_half_m1 = (col_eff >> 1) - COL_W'(1);
    assign row_half_m1 = (row_eff >> 1) - ROW_W'(1);

    always_ff @(posedge clk)
    begin
        if (emit_now)
        begin
            nb_reg[0] <= win_a0_reg;
            nb_reg[1] <= win_a1_reg;
            nb_reg[2] <= rd_a_reg;
            nb_reg[3] <= win_b0_reg;
            nb_reg[4] <= win_b1_reg;
            nb_reg[5] <= rd_b_reg;
            nb_reg[6] <= prev0_reg;
            nb_reg[7] <= prev1_reg;
            nb_reg[8] <= src.src_pixel;
            u0_reg    <= COORD_W'(COORD_W'(col_half_m1) * COORD_W'(3));
            v0_reg    <= COORD_W'(COORD_W'(row_half_m1) * COORD_W'(3));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            tap_reg       <= '0;
        end
        else if (emit_now)
        begin
            blk_valid_reg <= 1'b1;
            tap_reg       <= '0;
        end
        else if (blk_done)
        begin
            blk_valid_reg <= 1'b0;
            tap_reg       <= '0;
        end
        else if (emit_step)
        begin
            tap_reg <= tap_reg + TAP_W'(1);
        end
    end

    //------------------------------------------------------------------------
    // One result per cycle while the sink does not stall: weighted channel sums
    // over the nine taps, then truncation by the position's shift, and the screen placement.
    //------------------------------------------------------------------------
    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int t = 0; t < TAP_N; t++)
        begin
            sum_r = sum_r + SUM_W'(SUM_W'(TAP_WEIGHT[tap_reg][t]) * SUM_W'(nb_reg[t][15:11]));
            sum_g = sum_g + SUM_W'(SUM_W'(TAP_WEIGHT[tap_reg][t]) * SUM_W'(nb_reg[t][10:5]));
            sum_b = sum_b + SUM_W'(SUM_W'(TAP_WEIGHT[tap_reg][t]) * SUM_W'(nb_reg[t][4:0]));
        end
        sh_r = sum_r >> TAP_SHIFT[tap_reg];
        sh_g = sum_g >> TAP_SHIFT[tap_reg];
        sh_b = sum_b >> TAP_SHIFT[tap_reg];
    end

    assign u_cur = u0_reg + COORD_W'(TAP_DX[tap_reg]);
    assign v_cur = v0_reg + COORD_W'(TAP_DY[tap_reg]);

    always_comb
    begin
        if (landscape_reg)
        begin
            sx = LANDSCAPE_X_TOP - v_cur;
            sy = LANDSCAPE_Y_OFF + u_cur;
        end
        else
        begin
            sx = u_cur;
            sy = PORTRAIT_Y_OFF + v_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dst.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_step)
        begin
            screen_x_reg  <= sx;
            screen_y_reg  <= sy;
            out_pixel_reg <= {sh_r[4:0], sh_g[5:0], sh_b[4:0]};
            last_reg      <= (tap_reg == LAST_TAP);
        end
    end

    assign dst.valid         = out_valid_reg;
    assign dst.screen_x      = screen_x_reg;
    assign dst.screen_y      = screen_y_reg;
    assign dst.out_pixel     = out_pixel_reg;
    assign dst.last_of_block = last_reg;

    //------------------------------------------------------------------------
    // Assertions.
    //------------------------------------------------------------------------
    // A new block is never captured over one that still has results to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_now |-> (!blk_valid_reg || blk_done))
        else $error("block captured while previous block still pending");

    // Finishing a block leaves its ninth result, marked last, in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        blk_done |=> (dst.valid && dst.last_of_block))
        else $error("last result of block not presented");

    // The tap counter stays within the nine positions of a block.
    assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid_reg |-> (tap_reg <= LAST_TAP))
        else $error("tap counter out of range");

    // A held result is not replaced while the sink stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dst.valid && !dst.ready) |=> $stable(out_pixel_reg) && dst.valid)
        else $error("stalled result changed");

endmodule

`default_nettype wire
